// File: rtl/lavm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, stage indices and types for the look-at view-matrix unit.
package lavm_pkg;

  localparam int WORD_W      = 32;
  localparam int AX_W        = 18;
  localparam int UNIT        = 65536;
  localparam int FRAC        = 16;
  localparam int IN_TDATA_W  = 288;
  localparam int OUT_TDATA_W = 264;

  // Normaliser widths.
  localparam int NRM_IN_W      = 50;
  localparam int NRM_MAG_W     = 49;
  localparam int NRM_POS_W     = 6;
  localparam int NRM_M_W       = 30;
  localparam int NRM_M_TOP     = 29;
  localparam int NRM_SQ_W      = 64;
  localparam int NRM_SQ_STEPS  = 31;
  localparam int NRM_LEN_W     = 31;
  localparam int NRM_NUM_W     = 48;
  localparam int NRM_Q_W       = 17;
  localparam int NRM_DIV_STEPS = 17;

  // Normaliser stage indices.
  localparam int NRM_ST_SHIFT = 2;
  localparam int NRM_ST_RT0   = 5;
  localparam int NRM_ST_NUM   = NRM_ST_RT0 + NRM_SQ_STEPS;
  localparam int NRM_ST_OUT   = NRM_ST_NUM + 1 + NRM_DIV_STEPS;
  localparam int NRM_LAT      = NRM_ST_OUT + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } nrm_flag_t;

  typedef logic signed [AX_W-1:0]   ax_t;
  typedef logic signed [WORD_W-1:0] word_t;

endpackage

// File: rtl/lavm_norm.sv
`timescale 1ns / 1ps
// Pipelined three-component vector normaliser with integer square root and divider.
module lavm_norm #(
  parameter int SIDE_W = 192
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [lavm_pkg::NRM_IN_W-1:0] in_x,
  input  logic signed [lavm_pkg::NRM_IN_W-1:0] in_y,
  input  logic signed [lavm_pkg::NRM_IN_W-1:0] in_z,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output lavm_pkg::ax_t                        out_x,
  output lavm_pkg::ax_t                        out_y,
  output lavm_pkg::ax_t                        out_z,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int LAT      = lavm_pkg::NRM_LAT;
  localparam int IN_W     = lavm_pkg::NRM_IN_W;
  localparam int MAG_W    = lavm_pkg::NRM_MAG_W;
  localparam int POS_W    = lavm_pkg::NRM_POS_W;
  localparam int M_W      = lavm_pkg::NRM_M_W;
  localparam int M_TOP    = lavm_pkg::NRM_M_TOP;
  localparam int SQ_W     = lavm_pkg::NRM_SQ_W;
  localparam int RT_N     = lavm_pkg::NRM_SQ_STEPS;
  localparam int LEN_W    = lavm_pkg::NRM_LEN_W;
  localparam int NUM_W    = lavm_pkg::NRM_NUM_W;
  localparam int Q_W      = lavm_pkg::NRM_Q_W;
  localparam int DV_N     = lavm_pkg::NRM_DIV_STEPS;
  localparam int ST_SHIFT = lavm_pkg::NRM_ST_SHIFT;
  localparam int ST_NUM   = lavm_pkg::NRM_ST_NUM;
  localparam int FRAC     = lavm_pkg::FRAC;
  localparam int AX_W     = lavm_pkg::AX_W;

  logic                  vld_r  [LAT];
  logic [SIDE_W-1:0]     side_r [LAT];
  lavm_pkg::nrm_flag_t   flg_r  [LAT];

  logic signed [IN_W-1:0] in_v    [3];
  logic signed [IN_W-1:0] abs_c   [3];
  logic [MAG_W-1:0]       mag_r   [2][3];
  logic [MAG_W-1:0]       or_c;
  logic [POS_W-1:0]       pos_nxt;
  logic [POS_W-1:0]       pos_r;
  logic [M_W-1:0]         sh_nxt  [3];
  logic [M_W-1:0]         mc_r    [ST_SHIFT:ST_NUM-1][3];
  logic [2*M_W-1:0]       sq_r    [3];
  logic [SQ_W-1:0]        n_r;
  logic [SQ_W-1:0]        rt_n_nxt   [RT_N];
  logic [SQ_W-1:0]        rt_res_nxt [RT_N];
  logic [SQ_W-1:0]        rt_n_r     [RT_N];
  logic [SQ_W-1:0]        rt_res_r   [RT_N];
  logic [LEN_W-1:0]       len_c;
  logic [LEN_W-1:0]       len_r   [DV_N+1];
  logic [NUM_W-1:0]       rem_nxt [DV_N+1][3];
  logic [Q_W-1:0]         q_nxt   [DV_N+1][3];
  logic [NUM_W-1:0]       rem_r   [DV_N+1][3];
  logic [Q_W-1:0]         q_r     [DV_N+1][3];
  lavm_pkg::ax_t          o_nxt   [3];
  lavm_pkg::ax_t          o_r     [3];

  assign in_v[0] = in_x;
  assign in_v[1] = in_y;
  assign in_v[2] = in_z;

  // Magnitudes, leading-one position and the scaling shift.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      abs_c[l] = in_v[l][IN_W-1] ? -in_v[l] : in_v[l];
    end
    or_c    = mag_r[0][0] | mag_r[0][1] | mag_r[0][2];
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (or_c[i]) begin
        pos_nxt = POS_W'(i);
      end
    end
    for (int l = 0; l < 3; l++) begin
      if (pos_r >= POS_W'(M_TOP)) begin
        sh_nxt[l] = M_W'(mag_r[1][l] >> (pos_r - POS_W'(M_TOP)));
      end else begin
        sh_nxt[l] = M_W'(mag_r[1][l] << (POS_W'(M_TOP) - pos_r));
      end
    end
  end

  // One square-root digit per stage, highest weight first.
  always_comb begin
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    int              im1;
    for (int i = 0; i < RT_N; i++) begin
      im1 = (i > 0) ? i - 1 : 0;
      if (i == 0) begin
        n_in = n_r;
        r_in = '0;
      end else begin
        n_in = rt_n_r[im1];
        r_in = rt_res_r[im1];
      end
      bitv  = SQ_W'(1) << (2 * (RT_N - 1 - i));
      trial = r_in + bitv;
      if (n_in >= trial) begin
        rt_n_nxt[i]   = n_in - trial;
        rt_res_nxt[i] = (r_in >> 1) + bitv;
      end else begin
        rt_n_nxt[i]   = n_in;
        rt_res_nxt[i] = r_in >> 1;
      end
    end
  end

  // Rounded numerator, then one quotient bit per stage.
  always_comb begin
    logic [NUM_W-1:0] d;
    len_c = rt_res_r[RT_N-1][LEN_W-1:0];
    for (int l = 0; l < 3; l++) begin
      rem_nxt[0][l] = NUM_W'({mc_r[ST_NUM-1][l], {FRAC{1'b0}}}) + NUM_W'(len_c >> 1);
      q_nxt[0][l]   = '0;
    end
    for (int s = 0; s < DV_N; s++) begin
      d = NUM_W'(len_r[s]) << (DV_N - 1 - s);
      for (int l = 0; l < 3; l++) begin
        if (rem_r[s][l] >= d) begin
          rem_nxt[s+1][l] = rem_r[s][l] - d;
          q_nxt[s+1][l]   = q_r[s][l] | (Q_W'(1) << (DV_N - 1 - s));
        end else begin
          rem_nxt[s+1][l] = rem_r[s][l];
          q_nxt[s+1][l]   = q_r[s][l];
        end
      end
    end
    for (int l = 0; l < 3; l++) begin
      if (flg_r[LAT-2].zero) begin
        o_nxt[l] = '0;
      end else if (flg_r[LAT-2].neg[l]) begin
        o_nxt[l] = -$signed(AX_W'(q_r[DV_N][l]));
      end else begin
        o_nxt[l] = $signed(AX_W'(q_r[DV_N][l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]     <= in_side;
      flg_r[0].neg  <= {in_z[IN_W-1], in_y[IN_W-1], in_x[IN_W-1]};
      flg_r[0].zero <= 1'b0;
      flg_r[1].neg  <= flg_r[0].neg;
      flg_r[1].zero <= (or_c == '0);
      for (int k = 1; k < LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 2; k < LAT; k++) begin
        flg_r[k] <= flg_r[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        mag_r[0][l]        <= abs_c[l][MAG_W-1:0];
        mag_r[1][l]        <= mag_r[0][l];
        mc_r[ST_SHIFT][l]  <= sh_nxt[l];
        sq_r[l]            <= mc_r[ST_SHIFT][l] * mc_r[ST_SHIFT][l];
        o_r[l]             <= o_nxt[l];
      end
      for (int k = ST_SHIFT + 1; k < ST_NUM; k++) begin
        mc_r[k] <= mc_r[k-1];
      end
      pos_r <= pos_nxt;
      n_r   <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      for (int i = 0; i < RT_N; i++) begin
        rt_n_r[i]   <= rt_n_nxt[i];
        rt_res_r[i] <= rt_res_nxt[i];
      end
      len_r[0] <= len_c;
      for (int s = 1; s <= DV_N; s++) begin
        len_r[s] <= len_r[s-1];
      end
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_side  = side_r[LAT-1];
  assign out_x     = o_r[0];
  assign out_y     = o_r[1];
  assign out_z     = o_r[2];

endmodule

// File: rtl/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// Top level of the look-at view-matrix unit: camera set in, rotation and translation out.
//
// This unit takes one camera set per clock (eye point, target point and world-up vector,
// all signed Q16.16) and returns the view matrix for it: the normalised right axis, the
// camera up axis, the negated forward axis and the three translation terms, each
// translation rounded half away from zero and saturated to 32 bits. A vector of zero
// length normalises to zero, so an eye on its target or an up vector parallel to the
// view direction yields zero axes rather than an error. The unit is a fixed pipeline: a
// new item is accepted on every clock while the output side takes results. The pipeline
// depth comes chiefly from the two normalisers, each of which spends 55 stages, most of
// them in a 31-stage integer square root followed by a 17-stage divider. A two-entry
// output buffer lets the pipeline finish its current step when the consumer stalls; the
// whole pipeline then holds, and in_tready falls only while that buffer is full.
module look_at_view_matrix_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, sky_x, sky_y, sky_z, 32 bits each
  input  logic [lavm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // right_x/y/z, upaxis_x/y/z, back_x/y/z at 18 bits, shift_x/y/z at 32 bits, zero pad
  output logic [lavm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int W     = lavm_pkg::WORD_W;
  localparam int AX_W  = lavm_pkg::AX_W;
  localparam int NIN_W = lavm_pkg::NRM_IN_W;
  localparam int FRAC  = lavm_pkg::FRAC;
  localparam int OUT_W = lavm_pkg::OUT_TDATA_W;
  localparam int SIDE1 = 6 * W;
  localparam int SIDE2 = 3 * W + 3 * AX_W;
  localparam int PR_W  = AX_W + W;        // axis times coordinate
  localparam int UP_W  = 2 * AX_W;        // axis times axis
  localparam int UC_W  = UP_W + 1;        // cross-product component
  localparam int DS_W  = PR_W + 2;        // three-term dot product
  localparam int DQ_W  = DS_W - FRAC + 1; // rounded dot magnitude
  localparam int UQ_W  = UC_W - FRAC + 1; // rounded up-axis magnitude
  localparam int PAD_W = OUT_W - 9 * AX_W - 3 * W;

  function automatic lavm_pkg::word_t sat_word(input logic fneg, input logic [DQ_W-1:0] q);
    logic [DQ_W-1:0] nq;
    nq = -q;
    if (fneg) begin
      return (q > (DQ_W'(1) << (W - 1))) ? {1'b1, {(W-1){1'b0}}} : nq[W-1:0];
    end
    return (q > ((DQ_W'(1) << (W - 1)) - DQ_W'(1))) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
  endfunction

  // Output buffer and global advance.
  logic                en;
  logic                push;
  logic                out_vld_r;
  logic                skid_vld_r;
  logic [OUT_W-1:0]    out_dat_r;
  logic [OUT_W-1:0]    skid_dat_r;
  logic [OUT_W-1:0]    res_c;

  // Input and difference stages.
  logic                iv_r;
  logic                dv_r;
  lavm_pkg::word_t     eye_r [3];
  lavm_pkg::word_t     aim_r [3];
  lavm_pkg::word_t     sky_r [3];
  lavm_pkg::word_t     eye_d_r [3];
  lavm_pkg::word_t     sky_d_r [3];
  logic signed [W:0]   dir_r [3];
  logic signed [NIN_W-1:0] nin1 [3];
  logic [SIDE1-1:0]    side1;

  // First normaliser and right-axis cross product.
  logic                n1_vld;
  lavm_pkg::ax_t       fwd_c [3];
  logic [SIDE1-1:0]    n1_side;
  lavm_pkg::word_t     eye_1 [3];
  lavm_pkg::word_t     sky_1 [3];
  logic                c1_vld_r;
  logic                c2_vld_r;
  logic signed [PR_W-1:0] fs_r [6];
  lavm_pkg::word_t     eye_c_r [2][3];
  lavm_pkg::ax_t       fwd_cr_r [2][3];
  logic signed [NIN_W-1:0] rc_r [3];
  logic [SIDE2-1:0]    side2;

  // Second normaliser and the output arithmetic.
  logic                n2_vld;
  lavm_pkg::ax_t       rgt_c [3];
  logic [SIDE2-1:0]    n2_side;
  lavm_pkg::word_t     eye_2 [3];
  lavm_pkg::ax_t       fwd_2 [3];
  logic                vp_r [8];
  lavm_pkg::ax_t       rgt_p_r [8][3];
  lavm_pkg::ax_t       fwd_p_r [8][3];
  lavm_pkg::word_t     eye_p_r [4][3];
  logic signed [UP_W-1:0] ur_r [6];
  logic signed [PR_W-1:0] dr_r [3];
  logic signed [PR_W-1:0] df_r [3];
  logic signed [UC_W-1:0] upc_r [3];
  logic signed [DS_W-1:0] drs_r;
  logic signed [DS_W-1:0] dfs_r;
  logic [UC_W-1:0]     upm_r [3];
  logic [2:0]          upn_r;
  logic [DS_W-1:0]     drm_r;
  logic [DS_W-1:0]     dfm_r;
  logic                drn_r;
  logic                dfn_r;
  lavm_pkg::ax_t       upv_nxt [3];
  lavm_pkg::ax_t       upv_p_r [5][3];
  lavm_pkg::word_t     sx_p_r [5];
  lavm_pkg::word_t     sz_p_r [5];
  logic signed [PR_W-1:0] du_r [3];
  logic signed [DS_W-1:0] dus_r;
  logic [DS_W-1:0]     dum_r;
  logic                dun_r;
  lavm_pkg::word_t     sy_r;
  logic [DS_W:0]       drq_c;
  logic [DS_W:0]       dfq_c;
  logic [DS_W:0]       duq_c;

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign push      = en && vp_r[7];

  // Input register, then the full-precision view direction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= 1'b0;
      dv_r     <= 1'b0;
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      vp_r     <= '{default: 1'b0};
    end else if (en) begin
      iv_r     <= in_tvalid;
      dv_r     <= iv_r;
      c1_vld_r <= n1_vld;
      c2_vld_r <= c1_vld_r;
      vp_r[0]  <= n2_vld;
      for (int k = 1; k < 8; k++) begin
        vp_r[k] <= vp_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nin1[l]  = NIN_W'(dir_r[l]);
      eye_1[l] = n1_side[3*W + W*l +: W];
      sky_1[l] = n1_side[W*l +: W];
      eye_2[l] = n2_side[3*AX_W + W*l +: W];
      fwd_2[l] = n2_side[AX_W*l +: AX_W];
    end
    side1 = {eye_d_r[2], eye_d_r[1], eye_d_r[0], sky_d_r[2], sky_d_r[1], sky_d_r[0]};
    side2 = {eye_c_r[1][2], eye_c_r[1][1], eye_c_r[1][0],
             fwd_cr_r[1][2], fwd_cr_r[1][1], fwd_cr_r[1][0]};
  end

  lavm_norm #(
    .SIDE_W (SIDE1)
  ) u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_r),
    .in_x      (nin1[0]),
    .in_y      (nin1[1]),
    .in_z      (nin1[2]),
    .in_side   (side1),
    .out_valid (n1_vld),
    .out_x     (fwd_c[0]),
    .out_y     (fwd_c[1]),
    .out_z     (fwd_c[2]),
    .out_side  (n1_side)
  );

  lavm_norm #(
    .SIDE_W (SIDE2)
  ) u_norm_rgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c2_vld_r),
    .in_x      (rc_r[0]),
    .in_y      (rc_r[1]),
    .in_z      (rc_r[2]),
    .in_side   (side2),
    .out_valid (n2_vld),
    .out_x     (rgt_c[0]),
    .out_y     (rgt_c[1]),
    .out_z     (rgt_c[2]),
    .out_side  (n2_side)
  );

  // Rounding of the up axis and of the three dot products with the eye.
  always_comb begin
    logic [UC_W:0]   us;
    logic [UQ_W-1:0] uq;
    logic [AX_W-1:0] uqc;
    for (int l = 0; l < 3; l++) begin
      us  = (UC_W+1)'(upm_r[l]) + (UC_W+1)'(1 << (FRAC - 1));
      uq  = us[UC_W:FRAC];
      uqc = (uq > UQ_W'(lavm_pkg::UNIT)) ? AX_W'(lavm_pkg::UNIT) : uq[AX_W-1:0];
      upv_nxt[l] = upn_r[l] ? -$signed(uqc) : $signed(uqc);
    end
    drq_c = (DS_W+1)'(drm_r) + (DS_W+1)'(1 << (FRAC - 1));
    dfq_c = (DS_W+1)'(dfm_r) + (DS_W+1)'(1 << (FRAC - 1));
    duq_c = (DS_W+1)'(dum_r) + (DS_W+1)'(1 << (FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        eye_r[l]   <= in_tdata[W*l +: W];
        aim_r[l]   <= in_tdata[3*W + W*l +: W];
        sky_r[l]   <= in_tdata[6*W + W*l +: W];
        dir_r[l]   <= aim_r[l] - eye_r[l];
        eye_d_r[l] <= eye_r[l];
        sky_d_r[l] <= sky_r[l];
      end

      // Cross product of forward and world up.
      fs_r[0] <= fwd_c[1] * sky_1[2];
      fs_r[1] <= fwd_c[2] * sky_1[1];
      fs_r[2] <= fwd_c[2] * sky_1[0];
      fs_r[3] <= fwd_c[0] * sky_1[2];
      fs_r[4] <= fwd_c[0] * sky_1[1];
      fs_r[5] <= fwd_c[1] * sky_1[0];
      rc_r[0] <= NIN_W'(fs_r[0]) - NIN_W'(fs_r[1]);
      rc_r[1] <= NIN_W'(fs_r[2]) - NIN_W'(fs_r[3]);
      rc_r[2] <= NIN_W'(fs_r[4]) - NIN_W'(fs_r[5]);
      eye_c_r[0]  <= eye_1;
      fwd_cr_r[0] <= fwd_c;
      eye_c_r[1]  <= eye_c_r[0];
      fwd_cr_r[1] <= fwd_cr_r[0];

      // Axes and eye travel alongside the arithmetic.
      rgt_p_r[0] <= rgt_c;
      fwd_p_r[0] <= fwd_2;
      eye_p_r[0] <= eye_2;
      for (int k = 1; k < 8; k++) begin
        rgt_p_r[k] <= rgt_p_r[k-1];
        fwd_p_r[k] <= fwd_p_r[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        eye_p_r[k] <= eye_p_r[k-1];
      end

      // Camera up as right cross forward, and the dots with the eye.
      ur_r[0] <= rgt_c[1] * fwd_2[2];
      ur_r[1] <= rgt_c[2] * fwd_2[1];
      ur_r[2] <= rgt_c[2] * fwd_2[0];
      ur_r[3] <= rgt_c[0] * fwd_2[2];
      ur_r[4] <= rgt_c[0] * fwd_2[1];
      ur_r[5] <= rgt_c[1] * fwd_2[0];
      for (int l = 0; l < 3; l++) begin
        dr_r[l] <= rgt_c[l] * eye_2[l];
        df_r[l] <= fwd_2[l] * eye_2[l];
      end
      upc_r[0] <= UC_W'(ur_r[0]) - UC_W'(ur_r[1]);
      upc_r[1] <= UC_W'(ur_r[2]) - UC_W'(ur_r[3]);
      upc_r[2] <= UC_W'(ur_r[4]) - UC_W'(ur_r[5]);
      drs_r <= DS_W'(dr_r[0]) + DS_W'(dr_r[1]) + DS_W'(dr_r[2]);
      dfs_r <= DS_W'(df_r[0]) + DS_W'(df_r[1]) + DS_W'(df_r[2]);

      for (int l = 0; l < 3; l++) begin
        upm_r[l] <= upc_r[l][UC_W-1] ? -upc_r[l] : upc_r[l];
        upn_r[l] <= upc_r[l][UC_W-1];
      end
      drm_r <= drs_r[DS_W-1] ? -drs_r : drs_r;
      drn_r <= drs_r[DS_W-1];
      dfm_r <= dfs_r[DS_W-1] ? -dfs_r : dfs_r;
      dfn_r <= dfs_r[DS_W-1];

      // The right term is negated, the forward term is not.
      upv_p_r[0] <= upv_nxt;
      sx_p_r[0]  <= sat_word(!drn_r, drq_c[DS_W:FRAC]);
      sz_p_r[0]  <= sat_word(dfn_r, dfq_c[DS_W:FRAC]);
      for (int k = 1; k < 5; k++) begin
        upv_p_r[k] <= upv_p_r[k-1];
        sx_p_r[k]  <= sx_p_r[k-1];
        sz_p_r[k]  <= sz_p_r[k-1];
      end

      for (int l = 0; l < 3; l++) begin
        du_r[l] <= upv_p_r[0][l] * eye_p_r[3][l];
      end
      dus_r <= DS_W'(du_r[0]) + DS_W'(du_r[1]) + DS_W'(du_r[2]);
      dum_r <= dus_r[DS_W-1] ? -dus_r : dus_r;
      dun_r <= dus_r[DS_W-1];
      sy_r  <= sat_word(!dun_r, duq_c[DS_W:FRAC]);
    end
  end

  always_comb begin
    res_c = {PAD_W'(0), sz_p_r[4], sy_r, sx_p_r[4],
             -fwd_p_r[7][2], -fwd_p_r[7][1], -fwd_p_r[7][0],
             upv_p_r[4][2], upv_p_r[4][1], upv_p_r[4][0],
             rgt_p_r[7][2], rgt_p_r[7][1], rgt_p_r[7][0]};
  end

  // Two-entry output buffer: the second entry catches the item that was already
  // leaving the pipeline in the cycle the consumer stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_tready) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          out_dat_r  <= skid_dat_r;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= push;
          out_dat_r <= res_c;
        end
      end else if (push) begin
        skid_vld_r <= 1'b1;
        skid_dat_r <= res_c;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule
